// ===== src/rae_pkg.sv =====
// ----------------------------------------------------------------------------
// rae_pkg
// Shared types and constants of the rotation angle estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rae_pkg;

  localparam int FRAC_BITS_DEF   = 7;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int LIGHT_W         = 12;
  localparam int TIME_W          = 32;
  localparam int ANGLE_W         = 16;

  localparam logic [LIGHT_W-1:0] THRESH_RESET   = 12'd3500;
  localparam logic [TIME_W-1:0]  DEBOUNCE_RESET = 32'd50000;
  localparam int                 FULL_TURN_DEG  = 360;
  localparam logic [TIME_W-1:0]  AVG_DIVISOR    = 32'd10;

  // x / 10 == (x * AVG_RECIP10) >> AVG_RECIP_SHIFT for any 32-bit x
  localparam logic [TIME_W-1:0]  AVG_RECIP10     = 32'hCCCC_CCCD;
  localparam int                 AVG_RECIP_SHIFT = 35;

  // request queue between front and back
  localparam int CMD_DEPTH = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_US     = 1'd1;
  localparam int CFG_DATA_W = 32;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [LIGHT_W-1:0] light_sample;
    logic [TIME_W-1:0]  time_us;
  } in_req_t;

  typedef struct packed {
    logic               pass_seen;
    logic [ANGLE_W-1:0] angle_deg_q7;
    logic               angle_ok;
    logic               angle_overrun;
    logic [TIME_W-1:0]  avg_lap_us;
  } out_res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic              is_query;
    logic              bright;
    logic [TIME_W-1:0] time_us;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/rae_fifo.sv =====
// ----------------------------------------------------------------------------
// rae_fifo
// Short request queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_fifo
  import rae_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(CMD_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/rae_front.sv =====
// ----------------------------------------------------------------------------
// rae_front
// Configuration registers and request intake; classifies samples against
// the light threshold and queues requests for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_front
  import rae_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  input  wire in_req_t               in_data,
  input  wire logic                  fifo_full,
  output logic                       fifo_push,
  output cmd_t                       fifo_data,
  output logic [TIME_W-1:0]          debounce_us
);

  localparam int SB = (SAMPLE_BITS > LIGHT_W) ? LIGHT_W : SAMPLE_BITS;
  localparam logic [LIGHT_W-1:0] SAMPLE_MASK = LIGHT_W'((64'd1 << SB) - 64'd1);

  logic [LIGHT_W-1:0] thresh_r;
  logic [TIME_W-1:0]  debounce_r;
  logic [LIGHT_W-1:0] sample_used;

  assign cfg_ready   = 1'b1;
  assign debounce_us = debounce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= THRESH_RESET;
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIGHT_THRESHOLD: thresh_r   <= cfg_data[LIGHT_W-1:0];
        CFG_DEBOUNCE_US:     debounce_r <= cfg_data[TIME_W-1:0];
        default:             thresh_r   <= thresh_r;
      endcase
    end
  end

  assign sample_used = in_data.light_sample & SAMPLE_MASK;

  assign fifo_push          = in_push && !fifo_full;
  assign fifo_data.is_query = (in_data.req_type == REQ_QUERY);
  assign fifo_data.bright   = (sample_used > thresh_r);
  assign fifo_data.time_us  = in_data.time_us;

endmodule

`default_nettype wire

// ===== src/rae_div.sv =====
// ----------------------------------------------------------------------------
// rae_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_div
  import rae_pkg::*;
#(
  parameter int DIV_W = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic                   done,
  output logic [DIV_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [TIME_W-1:0] rem_r, den_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [TIME_W:0]   trial;
  logic [TIME_W+1:0] diff;
  logic              ge;

  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, den_r};
  assign ge       = !diff[TIME_W+1];
  assign rem_nxt  = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rae_back.sv =====
// ----------------------------------------------------------------------------
// rae_back
// Executes queued requests: passage detection, lap averaging and angle
// computation through a serial divider; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rae_back
  import rae_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fifo_empty,
  input  wire cmd_t              fifo_data,
  output logic                   fifo_pop,
  input  wire logic [TIME_W-1:0] debounce_us,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output out_res_t               out_data
);

  localparam int TURN   = FULL_TURN_DEG << FRAC_BITS;
  localparam int TURN_W = $clog2(TURN + 1);
  localparam int DIV_W  = TIME_W + TURN_W;
  localparam logic [DIV_W-1:0] TURN_Q = DIV_W'(TURN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_AVG_MUL,
    ST_AVG_UPD,
    ST_MULT,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state_r;
  cmd_t              cmd_r;
  logic [TIME_W-1:0] elapsed_r, last_pass_r, avg_r;
  logic [DIV_W-1:0]  prod_r;
  out_res_t          res_r, out_r;
  logic              out_valid_r;
  logic              avg_neg_r;
  logic [TIME_W-1:0] avg_mag_r, avg_q_r;

  logic              pass_c;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_quo, wrap1, wrap2;
  logic              overrun_c;
  logic [63:0]       recip_prod;
  logic [TIME_W-1:0] avg_nxt;
  logic              out_load;

  assign pass_c = !cmd_r.is_query && cmd_r.bright && (elapsed_r > debounce_us);

  // (avg*9 + lap)/10 == avg + floor((lap - avg)/10); a negative difference -m
  // gives avg - 1 - (m-1)/10, so only an unsigned 32-bit x/10 is needed
  assign recip_prod = 64'(avg_mag_r) * 64'(AVG_RECIP10);
  assign avg_nxt    = avg_r + (avg_neg_r ? ~avg_q_r : avg_q_r);

  assign div_start = (state_r == ST_MULT);

  rae_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (avg_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // one wrap, then saturate
  assign wrap1     = (div_quo >= TURN_Q) ? div_quo - TURN_Q : div_quo;
  assign overrun_c = (wrap1 >= TURN_Q);
  assign wrap2     = overrun_c ? TURN_Q - 1'b1 : wrap1;

  assign fifo_pop  = (state_r == ST_IDLE) && !fifo_empty;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmd_r       <= '0;
      elapsed_r   <= '0;
      last_pass_r <= '0;
      avg_r       <= '0;
      prod_r      <= '0;
      res_r       <= '0;
      out_r       <= '0;
      out_valid_r <= 1'b0;
      avg_neg_r   <= 1'b0;
      avg_mag_r   <= '0;
      avg_q_r     <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!fifo_empty) begin
            cmd_r     <= fifo_data;
            elapsed_r <= fifo_data.time_us - last_pass_r;
            state_r   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          res_r <= {1'b0, ANGLE_W'(0), 1'b0, 1'b0, avg_r};
          if (cmd_r.is_query) begin
            if (avg_r == '0) begin
              state_r <= ST_DONE;
            end else begin
              prod_r  <= DIV_W'(elapsed_r) * TURN_Q;
              state_r <= ST_MULT;
            end
          end else if (pass_c) begin
            if (elapsed_r >= avg_r) begin
              avg_neg_r <= 1'b0;
              avg_mag_r <= elapsed_r - avg_r;
            end else begin
              avg_neg_r <= 1'b1;
              avg_mag_r <= avg_r + ~elapsed_r;
            end
            state_r <= ST_AVG_MUL;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_AVG_MUL: begin
          avg_q_r <= TIME_W'(recip_prod[63:AVG_RECIP_SHIFT]);
          state_r <= ST_AVG_UPD;
        end
        ST_AVG_UPD: begin
          avg_r       <= avg_nxt;
          last_pass_r <= cmd_r.time_us;
          res_r       <= {1'b1, ANGLE_W'(0), 1'b0, 1'b0, avg_nxt};
          state_r     <= ST_DONE;
        end
        ST_MULT: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            res_r   <= {1'b0, wrap2[ANGLE_W-1:0], !overrun_c, overrun_c, avg_r};
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_r   <= res_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/rotation_angle_estimator.sv =====
// ----------------------------------------------------------------------------
// rotation_angle_estimator
// Angle of a spinning sensor from a once-per-turn light pulse.
//
// Input queue side: in_data carries a light sample or an angle query; it is
// taken when in_push is high and in_full is low. A two-entry request queue
// separates intake from execution, so requests keep flowing in while the
// back end is busy or a result waits.
// Result side: while out_empty is low, out_data holds the oldest result;
// out_pop takes it. If the receiver stalls, the finished result sits in the
// output register, the back end holds its next result, then the queue fills
// and in_full rises.
// Config port: cfg_valid/cfg_index/cfg_data, cfg_ready always high; write
// only while idle.
// From acceptance to out_empty low: a non-passage sample or a zero-average
// query is evaluated and done; a passage adds a reciprocal multiply for /10;
// a query at FRAC_BITS = 7 adds a 48-bit serial division, bit by bit. The
// back end starts the next request only once the output register is loaded.
// Reset (rst_n low, synchronous): threshold 3500, debounce 50000 us, last
// passage time and average lap zero, queues empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_angle_estimator
  import rae_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire in_req_t               in_data,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output out_res_t                   out_data
);

  logic              fifo_push, fifo_full, fifo_pop, fifo_empty;
  cmd_t              fifo_wdata, fifo_rdata;
  logic [TIME_W-1:0] debounce_us;

  assign in_full = fifo_full;

  rae_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_push     (in_push),
    .in_data     (in_data),
    .fifo_full   (fifo_full),
    .fifo_push   (fifo_push),
    .fifo_data   (fifo_wdata),
    .debounce_us (debounce_us)
  );

  rae_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (fifo_wdata),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .pop_data  (fifo_rdata),
    .empty     (fifo_empty)
  );

  rae_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .fifo_empty  (fifo_empty),
    .fifo_data   (fifo_rdata),
    .fifo_pop    (fifo_pop),
    .debounce_us (debounce_us),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/rae_result_checker.sv =====
// ----------------------------------------------------------------------------
// rae_result_checker
// Watches the request, result and register channels of the rotation angle
// estimator. It keeps its own copy of the passage time, average lap and
// registers, works out the expected result of every accepted request, and
// compares each popped result against the oldest one waiting.
// ----------------------------------------------------------------------------
module rae_result_checker
  import rae_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  input  logic                  in_full,
  input  in_req_t               in_data,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  out_res_t              out_data,
  output int                    fail_count,
  output int                    pending_count,
  output int                    passages,
  output int                    valid_angles,
  output int                    overruns,
  output int                    no_average_queries,
  output int                    full_stalls
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] TURN_FIXED     = 64'(FULL_TURN_DEG) << FRAC_BITS;
  localparam logic [63:0] AVG_OLD_WEIGHT = 64'd9;
  localparam logic [31:0] SAMPLE_MASK    = 32'((64'd1 << SAMPLE_BITS) - 1);
  localparam int          MAX_REPORTS    = 10;

  logic [LIGHT_W-1:0] threshold    = THRESH_RESET;
  logic [TIME_W-1:0]  debounce     = DEBOUNCE_RESET;
  logic [TIME_W-1:0]  last_pass_us = '0;
  logic [TIME_W-1:0]  avg_lap      = '0;

  out_res_t expected_results[$];

  int n_fail     = 0;
  int n_passages = 0;
  int n_valid    = 0;
  int n_overrun  = 0;
  int n_no_avg   = 0;
  int n_stalls   = 0;

  assign passages           = n_passages;
  assign valid_angles       = n_valid;
  assign overruns           = n_overrun;
  assign no_average_queries = n_no_avg;
  assign full_stalls        = n_stalls;

  // Result of one request; advances passage time and average on a passage.
  function automatic out_res_t estimate_result(in_req_t req);
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       sum;
    logic [63:0]       q;
    out_res_t          res;
    res = '0;
    elapsed = req.time_us - last_pass_us;
    if (req.req_type == REQ_SAMPLE) begin
      if ((32'(req.light_sample) & SAMPLE_MASK) > 32'(threshold) && elapsed > debounce) begin
        sum = 64'(avg_lap) * AVG_OLD_WEIGHT + 64'(elapsed);
        avg_lap = 32'(sum / 64'(AVG_DIVISOR));
        last_pass_us = req.time_us;
        res.pass_seen = 1'b1;
      end
    end else if (avg_lap != '0) begin
      q = (64'(elapsed) * TURN_FIXED) / 64'(avg_lap);
      if (q >= TURN_FIXED) begin
        q = q - TURN_FIXED;
      end
      if (q >= TURN_FIXED) begin
        q = TURN_FIXED - 1;
        res.angle_overrun = 1'b1;
      end else begin
        res.angle_ok = 1'b1;
      end
      res.angle_deg_q7 = q[ANGLE_W-1:0];
    end
    res.avg_lap_us = avg_lap;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_res_t want;
    if (!rst_n) begin
      threshold    = THRESH_RESET;
      debounce     = DEBOUNCE_RESET;
      last_pass_us = '0;
      avg_lap      = '0;
      expected_results.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("%0t: result popped with no request outstanding: avg=%0d", $time,
                     out_data.avg_lap_us);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected pass=%0b angle=%0d ok=%0b overrun=%0b avg=%0d",
                       $time, want.pass_seen, want.angle_deg_q7, want.angle_ok,
                       want.angle_overrun, want.avg_lap_us);
              $display("%0t:           actual pass=%0b angle=%0d ok=%0b overrun=%0b avg=%0d",
                       $time, out_data.pass_seen, out_data.angle_deg_q7, out_data.angle_ok,
                       out_data.angle_overrun, out_data.avg_lap_us);
            end
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LIGHT_THRESHOLD: threshold = cfg_data[LIGHT_W-1:0];
          CFG_DEBOUNCE_US:     debounce  = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end

      if (in_push && in_full) n_stalls++;

      if (in_push && !in_full) begin
        want = estimate_result(in_data);
        expected_results.push_back(want);
        if (want.pass_seen) n_passages++;
        if (want.angle_ok) n_valid++;
        if (want.angle_overrun) n_overrun++;
        if (in_data.req_type == REQ_QUERY && !want.angle_ok && !want.angle_overrun) n_no_avg++;
      end
    end
    fail_count    <= n_fail;
    pending_count <= expected_results.size();
  end

endmodule

// ===== bench/tb_rotation_angle_estimator.sv =====
// ----------------------------------------------------------------------------
// tb_rotation_angle_estimator
// Drives light samples and angle queries into the estimator: a directed set
// of edge cases after reset, then simulated rotations with random timing
// under several threshold and debounce settings, mixed with random noise.
// Both channel sides idle at random, and one long receiver hold fills the
// block. Checking is done by rae_result_checker.
// ----------------------------------------------------------------------------
module tb_rotation_angle_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  import rae_pkg::*;

  localparam int MODE2_AT    = 640;
  localparam int MODE3_AT    = 1280;
  localparam int PRESSURE_AT = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam int END_CYCLES  = 100;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_push   = 1'b0;
  logic                  in_full;
  in_req_t               in_data   = '0;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  out_res_t              out_data;

  int fail_count;
  int pending_count;
  int passages;
  int valid_angles;
  int overruns;
  int no_average_queries;
  int full_stalls;

  int   send_idle_pct = 32;
  int   recv_idle_pct = 80;
  logic hold_go       = 1'b0;
  logic hold_done     = 1'b0;
  int   hold_left     = 0;
  int   n_sent        = 0;
  int   n_settings    = 0;

  // shaping state of the simulated rotation
  logic [LIGHT_W-1:0] thr_now    = THRESH_RESET;
  logic [TIME_W-1:0]  now_us     = '0;
  logic [TIME_W-1:0]  since_pass = '0;

  rotation_angle_estimator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  rae_result_checker i_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data            (in_data),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_data           (out_data),
    .fail_count         (fail_count),
    .pending_count      (pending_count),
    .passages           (passages),
    .valid_angles       (valid_angles),
    .overruns           (overruns),
    .no_average_queries (no_average_queries),
    .full_stalls        (full_stalls)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random pops, plus one long hold to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      out_pop   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_pop   <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic in_req_t mk_req(logic kind, logic [LIGHT_W-1:0] level,
                                     logic [TIME_W-1:0] t);
    in_req_t req;
    req.req_type     = kind;
    req.light_sample = level;
    req.time_us      = t;
    return req;
  endfunction

  function automatic logic [LIGHT_W-1:0] bright_level();
    if (thr_now == '1) return '1;
    return LIGHT_W'($urandom_range(32'(thr_now) + 1, 4095));
  endfunction

  task automatic offer(in_req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_full);
    n_sent++;
    if (n_sent == MODE2_AT) begin
      send_idle_pct = 80;
      recv_idle_pct <= 32;
    end else if (n_sent == MODE3_AT) begin
      send_idle_pct = 0;
      recv_idle_pct <= 0;
    end else if (n_sent == PRESSURE_AT) begin
      hold_go <= 1'b1;
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One register setting, then a rotation of roughly constant lap with
  // random sample spacing, queries at and beyond the current time, bright
  // glitches at the current sample time, and random noise requests.
  task automatic run_setting(logic [LIGHT_W-1:0] thr, logic [TIME_W-1:0] deb, int n,
                             logic [TIME_W-1:0] lap_lo, logic [TIME_W-1:0] lap_hi);
    logic [TIME_W-1:0] lap;
    logic [TIME_W-1:0] cur_lap;
    logic [TIME_W-1:0] step;
    in_req_t           req;
    int                k;
    write_reg(CFG_LIGHT_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_DEBOUNCE_US, deb);
    thr_now = thr;
    n_settings++;
    lap = $urandom_range(lap_lo, lap_hi);
    cur_lap = lap;
    repeat (n) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        req = mk_req(1'($urandom), LIGHT_W'($urandom), $urandom);
      end else if (k < 28) begin
        req = mk_req(REQ_QUERY, LIGHT_W'($urandom), now_us);
      end else if (k < 40) begin
        req = mk_req(REQ_QUERY, LIGHT_W'($urandom), now_us + $urandom_range(0, 3 * lap));
      end else if (k < 45) begin
        req = mk_req(REQ_SAMPLE, bright_level(), now_us);
      end else begin
        step = $urandom_range(1, lap / 4 + 1);
        now_us += step;
        since_pass += step;
        if (since_pass >= cur_lap) begin
          req = mk_req(REQ_SAMPLE, bright_level(), now_us);
          since_pass = '0;
          cur_lap = lap + $urandom_range(0, lap / 8);
        end else begin
          req = mk_req(REQ_SAMPLE, LIGHT_W'($urandom_range(0, 32'(thr_now))), now_us);
        end
      end
      offer(req);
    end
  endtask

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [TIME_W-1:0] deb;
    logic [LIGHT_W-1:0] thr;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // no average yet
    offer(mk_req(REQ_QUERY,  12'hFFF, 32'd0));
    offer(mk_req(REQ_QUERY,  12'h000, 32'hFFFF_FFFF));
    // debounce and threshold boundaries, then the first passage from time 0
    offer(mk_req(REQ_SAMPLE, 12'hFFF, 32'd50000));
    offer(mk_req(REQ_SAMPLE, 12'd3500, 32'd60000));
    offer(mk_req(REQ_SAMPLE, 12'd3501, 32'd50001));
    offer(mk_req(REQ_SAMPLE, 12'h000, 32'hFFFF_FFFF));
    // average is 5000 here: zero, half turn, one wrap, just below and at overrun
    offer(mk_req(REQ_QUERY,  12'h000, 32'd50001));
    offer(mk_req(REQ_QUERY,  12'h000, 32'd52501));
    offer(mk_req(REQ_QUERY,  12'h000, 32'd55001));
    offer(mk_req(REQ_QUERY,  12'h000, 32'd60000));
    offer(mk_req(REQ_QUERY,  12'h000, 32'd60001));
    offer(mk_req(REQ_QUERY,  12'hFFF, 32'd50000));
    offer(mk_req(REQ_SAMPLE, 12'hFFF, 32'd100001));
    offer(mk_req(REQ_SAMPLE, 12'hFFF, 32'd100002));
    // passages around the time wrap
    offer(mk_req(REQ_SAMPLE, 12'hFFF, 32'hFFFF_FFF0));
    offer(mk_req(REQ_QUERY,  12'h000, 32'h0000_0100));
    offer(mk_req(REQ_SAMPLE, 12'hFFF, 32'h0001_0000));
    offer(mk_req(REQ_QUERY,  12'h000, 32'h0001_0000));

    now_us = 32'h0001_0000;
    since_pass = '0;

    run_setting(THRESH_RESET, DEBOUNCE_RESET, 300, 60000, 200000);
    run_setting(12'd0, 32'd0, 300, 4, 400);
    run_setting(12'hFFF, 32'hFFFF_FFFF, 100, 1000, 1000);
    run_setting(12'd2048, 32'd1000, 300, 2000, 20000);
    thr = LIGHT_W'($urandom_range(0, 4095));
    deb = $urandom_range(0, 1 << 20);
    run_setting(thr, deb, 300, deb + 1, 2 * deb + 100);
    // long laps: large averages and frequent time wrap
    thr = LIGHT_W'($urandom_range(0, 4095));
    deb = $urandom_range(1 << 24, 1 << 29);
    run_setting(thr, deb, 300, deb + 1, deb + (1 << 29));
    run_setting(THRESH_RESET, DEBOUNCE_RESET, 300, 50001, 150000);

    drain();
    repeat (END_CYCLES) @(posedge clk);

    $display("Sent %0d requests over %0d register settings: %0d passages, %0d valid angles,",
             n_sent, n_settings, passages, valid_angles);
    $display("%0d overruns, %0d queries with no average, input held off by full for %0d cycles",
             overruns, no_average_queries, full_stalls);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rae_pkg.sv
src/rae_fifo.sv
src/rae_front.sv
src/rae_div.sv
src/rae_back.sv
src/rotation_angle_estimator.sv
bench/rae_result_checker.sv
bench/tb_rotation_angle_estimator.sv
